// File: rtl/core/asr_pkg.sv
// Shared types and constants of the azimuth stretch resampler.
// Depends on nothing; every other file of the block imports it.
package asr_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int ROW_BITS    = 14;
  localparam int CNT_BITS    = 15;
  localparam int W_BITS      = 22;
  localparam int POS_BITS    = 49;
  localparam int PROD_BITS   = 56;
  localparam int BASE_BITS   = 23;
  localparam int OM_BITS     = 33;
  localparam int BOP_BITS    = 25;
  localparam int T_BITS      = 42;

  // |coef| * valid lines limit: 10.0 in units of 2^-31
  localparam logic [46:0] ERR_LIMIT = 47'd21474836480;
  localparam logic [T_BITS-1:0] WEIGHT_LIM = T_BITS'(1 << 20);

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_COEF  = 3'd0;
  localparam logic [2:0] REG_RECIP = 3'd1;
  localparam logic [2:0] REG_PATCH = 3'd2;
  localparam logic [2:0] REG_VALID = 3'd3;
  localparam logic [2:0] REG_ROWS  = 3'd4;

  typedef struct packed {
    logic [31:0] coef;
    logic [7:0]  patch;
    logic [14:0] valid;
    logic [14:0] rows;
  } cfg_t;

  typedef struct packed {
    logic                          pass;
    logic                          err;
    logic                          last;
    logic [ROW_BITS-1:0]           row;
    logic signed [SAMPLE_BITS-1:0] p_re;
    logic signed [SAMPLE_BITS-1:0] p_im;
    logic signed [SAMPLE_BITS-1:0] c_re;
    logic signed [SAMPLE_BITS-1:0] c_im;
    logic signed [W_BITS-1:0]      wp;
    logic signed [W_BITS-1:0]      wc;
  } job_t;

endpackage

// File: rtl/core/asr_if.sv
// Valid/ready channel interfaces of the resampler: sample input and result output.
// Depends on asr_pkg.
interface asr_in_if import asr_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_re;
  logic signed [SAMPLE_BITS-1:0] sample_im;
  logic                          first_of_column;
  modport source (output valid, sample_re, sample_im, first_of_column, input ready);
  modport sink (input valid, sample_re, sample_im, first_of_column, output ready);
endinterface

interface asr_out_if import asr_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_re;
  logic signed [SAMPLE_BITS-1:0] out_im;
  logic [ROW_BITS-1:0]           out_row;
  logic                          last_of_run;
  logic                          config_error;
  modport source (output valid, out_re, out_im, out_row, last_of_run, config_error,
                  input ready);
  modport sink (input valid, out_re, out_im, out_row, last_of_run, config_error,
                output ready);
endinterface

// File: rtl/core/azimuth_stretch_resampler.sv
// Top level of the azimuth stretch resampler: register port, front, queue, back.
// Depends on asr_pkg, asr_if, asr_front, asr_queue and asr_back.
//
// Usage:
//   in_ch   valid/ready channel of column samples; first_of_column marks span start.
//   out_ch  valid/ready channel of resampled samples, zero to two per input
//           transfer; last_of_run marks the final one of a step, config_error
//           flags a stretch too large (one result per sample, no data).
//   APB     five registers at byte addresses 0,4,8,12,16; pready is tied high.
//           Write only while the block is idle.
// Flow: the front takes a new sample only after its serial sequencer (classify,
//   position multiply, emit, a second emit when a step yields two results) is done
//   with the last one; a flagged sample or one past the span end skips multiply and emit.
// Path: each job goes from the front through the job queue; the back end is a
//   4-stage multiply/round pipeline.
// Reset: synchronous, active low; registers take their defaults and the column
//   counters, previous sample and position clear.
// Stall: when out_ch is held off, the back pipeline freezes, the 2-entry job
//   queue fills and then the front holds, dropping nothing.
module azimuth_stretch_resampler import asr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  asr_in_if.sink      in_ch,
  asr_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] coef_r, recip_r;
  logic [7:0]  patch_r;
  logic [14:0] valid_r, rows_r;
  logic        wr_en;
  cfg_t        cfg;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r  <= 32'd0;
      recip_r <= 32'h4000_0000;
      patch_r <= 8'd1;
      valid_r <= 15'd16384;
      rows_r  <= 15'd16384;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_COEF:  coef_r  <= pwdata;
        REG_RECIP: recip_r <= pwdata;
        REG_PATCH: patch_r <= pwdata[7:0];
        REG_VALID: valid_r <= pwdata[14:0];
        REG_ROWS:  rows_r  <= pwdata[14:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_COEF:  prdata = coef_r;
      REG_RECIP: prdata = recip_r;
      REG_PATCH: prdata = {24'd0, patch_r};
      REG_VALID: prdata = {17'd0, valid_r};
      REG_ROWS:  prdata = {17'd0, rows_r};
      default:   prdata = 32'd0;
    endcase
  end

  assign cfg = '{coef: coef_r, patch: patch_r, valid: valid_r, rows: rows_r};

  job_t f_job, b_job;
  logic f_valid, f_ready, b_valid, b_ready;

  asr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .job       (f_job),
    .job_valid (f_valid),
    .job_ready (f_ready)
  );

  asr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_job   (f_job),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_job    (b_job),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready)
  );

  asr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (b_job),
    .job_valid (b_valid),
    .job_ready (b_ready),
    .recip     (recip_r),
    .out_ch    (out_ch)
  );

endmodule

// File: rtl/core/asr_front.sv
// Front end: takes samples, forms stretched positions and splits each step into jobs.
// Depends on asr_pkg and asr_if.
module asr_front import asr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  asr_in_if.sink   in_ch,
  input  cfg_t     cfg,
  output job_t     job,
  output logic     job_valid,
  input  logic     job_ready
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;
  localparam logic [2:0] ST_EMIT2 = 3'd4;

  logic [2:0]                    state_r;
  logic signed [SAMPLE_BITS-1:0] re_r, im_r, prev_re_r, prev_im_r;
  logic                          first_r;
  logic [BASE_BITS-1:0]          base_r;
  logic [OM_BITS-1:0]            om_r;
  logic [CNT_BITS-1:0]           span_r, in_cnt_r, out_cnt_r;
  logic [PROD_BITS-1:0]          prod_r;
  logic [POS_BITS-1:0]           prev_pos_r;
  logic [BOP_BITS-1:0]           bop_r;

  function automatic logic signed [W_BITS-1:0] wdiff(input logic [T_BITS-1:0] a,
                                                     input logic [T_BITS-1:0] b);
    logic [T_BITS-1:0] d;
    logic              neg;
    neg = (a < b);
    d = neg ? (b - a) : (a - b);
    if (d > WEIGHT_LIM) d = WEIGHT_LIM;
    return neg ? -$signed(d[W_BITS-1:0]) : $signed(d[W_BITS-1:0]);
  endfunction

  // Classification of the sample held in the front
  logic [31:0]          cmag;
  logic [46:0]          err_prod;
  logic                 err;
  logic [CNT_BITS-1:0]  low, span, i_eff;
  logic [7:0]           patch_m1;
  logic [OM_BITS-1:0]   om;

  assign cmag     = cfg.coef[31] ? (32'd0 - cfg.coef) : cfg.coef;
  assign err_prod = 47'(cmag) * 47'(cfg.valid);
  assign err      = (err_prod >= ERR_LIMIT);
  assign low      = (cfg.rows >= cfg.valid) ? ((cfg.rows - cfg.valid) >> 1) : '0;
  assign span     = cfg.rows - low;
  assign i_eff    = first_r ? '0 : in_cnt_r;
  assign patch_m1 = (cfg.patch == 8'd0) ? 8'd0 : (cfg.patch - 8'd1);
  assign om       = {1'b0, 32'h8000_0000} - {cfg.coef[31], cfg.coef};

  // Position and step classification
  logic [POS_BITS-1:0]  pos;
  logic                 i0, room, dx1, dx2, emit_now, adv;
  logic [25:0]          dx;
  logic [T_BITS-1:0]    xc, xp, t;

  assign pos  = prod_r[PROD_BITS-1:7];
  assign i0   = (in_cnt_r == '0);
  assign room = ({1'b0, out_cnt_r} + 16'd1) < {1'b0, span_r};
  assign dx   = {1'b0, pos[48:24]} - {1'b0, prev_pos_r[48:24]};
  assign dx1  = (dx == 26'd1);
  assign dx2  = (dx == 26'd2);
  assign xc   = {1'b0, pos[48:8]};
  assign xp   = {1'b0, prev_pos_r[48:8]};
  assign t    = {({1'b0, bop_r} + 26'(out_cnt_r)), 16'd0};
  assign emit_now = room && (i0 || dx1 || dx2);
  assign adv  = !emit_now || job_ready;

  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    job      = '0;
    job.row  = out_cnt_r[ROW_BITS-1:0];
    job.p_re = prev_re_r;
    job.p_im = prev_im_r;
    job.c_re = re_r;
    job.c_im = im_r;
    job.wp   = wdiff(xc, t);
    job.wc   = wdiff(t, xp);
    job.pass = i0;
    job.last = (state_r == ST_EMIT2) || i0 || dx1;
    job_valid = 1'b0;
    unique case (state_r)
      ST_PREP: begin
        if (err) begin
          job      = '0;
          job.pass = 1'b1;
          job.err  = 1'b1;
          job.last = 1'b1;
          job_valid = 1'b1;
        end
      end
      ST_EMIT:  job_valid = emit_now;
      ST_EMIT2: job_valid = 1'b1;
      default:  job_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_ch.valid) begin
      re_r    <= in_ch.sample_re;
      im_r    <= in_ch.sample_im;
      first_r <= in_ch.first_of_column;
    end
    if (state_r == ST_PREP) begin
      base_r <= BASE_BITS'(patch_m1 * cfg.valid);
      om_r   <= om;
      span_r <= span;
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_BITS'(PROD_BITS'(base_r + BASE_BITS'(in_cnt_r)) * PROD_BITS'(om_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      prev_re_r  <= '0;
      prev_im_r  <= '0;
      prev_pos_r <= '0;
      in_cnt_r   <= '0;
      out_cnt_r  <= '0;
      bop_r      <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) state_r <= ST_PREP;
        end
        ST_PREP: begin
          if (err) begin
            // hold state untouched, only report the error
            if (job_ready) state_r <= ST_IDLE;
          end else begin
            if (first_r) begin
              in_cnt_r  <= '0;
              out_cnt_r <= '0;
            end
            state_r <= (i_eff >= span) ? ST_IDLE : ST_MUL;
          end
        end
        ST_MUL: state_r <= ST_EMIT;
        ST_EMIT: begin
          if (adv) begin
            if (emit_now) out_cnt_r <= out_cnt_r + 1'b1;
            if (!i0 && room && dx2) begin
              state_r <= ST_EMIT2;
            end else begin
              prev_re_r  <= re_r;
              prev_im_r  <= im_r;
              prev_pos_r <= pos;
              in_cnt_r   <= in_cnt_r + 1'b1;
              if (i0) bop_r <= prod_r[PROD_BITS-1:31];
              state_r <= ST_IDLE;
            end
          end
        end
        ST_EMIT2: begin
          if (job_ready) begin
            out_cnt_r  <= out_cnt_r + 1'b1;
            prev_re_r  <= re_r;
            prev_im_r  <= im_r;
            prev_pos_r <= pos;
            in_cnt_r   <= in_cnt_r + 1'b1;
            state_r    <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/asr_queue.sv
// Two-entry job queue between front and back end.
// Depends on asr_pkg.
module asr_queue import asr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  job_t push_job,
  input  logic push_valid,
  output logic push_ready,
  output job_t pop_job,
  output logic pop_valid,
  input  logic pop_ready
);

  job_t       mem [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_job    = mem[rptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= !wptr_r;
      if (pop)  rptr_r <= !rptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: rtl/core/asr_back.sv
// Back end: weighted sum, reciprocal scale, round and saturate; pass jobs bypass.
// Depends on asr_pkg and asr_if.
module asr_back import asr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       job,
  input  logic       job_valid,
  output logic       job_ready,
  input  logic [31:0] recip,
  asr_out_if.source  out_ch
);

  typedef struct packed {
    logic                          pass;
    logic                          err;
    logic                          last;
    logic [ROW_BITS-1:0]           row;
    logic signed [SAMPLE_BITS-1:0] c_re;
    logic signed [SAMPLE_BITS-1:0] c_im;
  } meta_t;

  function automatic logic signed [SAMPLE_BITS-1:0] finish(input logic neg,
                                                          input logic [47:0] x);
    logic [33:0] r;
    r = 34'((x + 48'd8192) >> 14);
    if (neg) begin
      if (r >= 34'd8388608) return -24'sd8388608;
      return -$signed(r[SAMPLE_BITS-1:0]);
    end
    if (r >= 34'd8388607) return 24'sd8388607;
    return $signed(r[SAMPLE_BITS-1:0]);
  endfunction

  logic              adv;
  logic              v1_r, v2_r, v3_r;
  meta_t             m1_r, m2_r, m3_r;
  logic signed [46:0] s_re_r, s_im_r;
  logic [46:0]       mag_re_r, mag_im_r;
  logic              neg_re2_r, neg_im2_r, neg_re3_r, neg_im3_r;
  logic [63:0]       plo_re_r, plo_im_r;
  logic [46:0]       phi_re_r, phi_im_r;
  logic              out_valid_r;

  assign adv       = !out_valid_r || out_ch.ready;
  assign job_ready = adv;
  assign out_ch.valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      // weighted sum of neighbors
      s_re_r <= 47'(job.p_re * job.wp) + 47'(job.c_re * job.wc);
      s_im_r <= 47'(job.p_im * job.wp) + 47'(job.c_im * job.wc);
      m1_r   <= '{job.pass, job.err, job.last, job.row, job.c_re, job.c_im};
      // sign and magnitude
      neg_re2_r <= s_re_r[46];
      neg_im2_r <= s_im_r[46];
      mag_re_r  <= s_re_r[46] ? 47'(-s_re_r) : 47'(s_re_r);
      mag_im_r  <= s_im_r[46] ? 47'(-s_im_r) : 47'(s_im_r);
      m2_r      <= m1_r;
      // reciprocal scaling in two partial products
      plo_re_r  <= 64'(mag_re_r[31:0]) * 64'(recip);
      plo_im_r  <= 64'(mag_im_r[31:0]) * 64'(recip);
      phi_re_r  <= 47'(mag_re_r[46:32]) * 47'(recip);
      phi_im_r  <= 47'(mag_im_r[46:32]) * 47'(recip);
      neg_re3_r <= neg_re2_r;
      neg_im3_r <= neg_im2_r;
      m3_r      <= m2_r;
      if (v3_r) begin
        out_ch.out_row      <= m3_r.row;
        out_ch.last_of_run  <= m3_r.last;
        out_ch.config_error <= m3_r.err;
        out_ch.out_re <= m3_r.pass ? m3_r.c_re
                                   : finish(neg_re3_r, 48'(phi_re_r) + 48'(plo_re_r[63:32]));
        out_ch.out_im <= m3_r.pass ? m3_r.c_im
                                   : finish(neg_im3_r, 48'(phi_im_r) + 48'(plo_im_r[63:32]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= job_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

endmodule
